@@ hdl/ogg_last_granule_scanner_macros.svh @@
// assertion macros for the ogg last granule scanner
`ifndef OGG_LAST_GRANULE_SCANNER_MACROS_SVH
`define OGG_LAST_GRANULE_SCANNER_MACROS_SVH

// same-cycle implication
`define OGG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogg scanner assertion failed");

// next-cycle implication
`define OGG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogg scanner assertion failed");

`endif

@@ hdl/ogg_lgs_pkg.sv @@
// shared types and constants for the ogg last granule scanner
`default_nettype none
package ogg_lgs_pkg;

    localparam int BYTE_W    = 8;
    localparam int GRANULE_W = 64;
    localparam int WINDOW_W  = 24;
    localparam int HIDX_W    = 5;
    localparam int SEG_W     = 8;
    localparam int BODY_W    = 16;
    localparam int GRAN_BYTES = GRANULE_W / BYTE_W;

    localparam logic [HIDX_W-1:0]   HDR_LAST      = 5'd26;
    localparam logic [HIDX_W-1:0]   HDR_START     = 5'd4;
    localparam logic [HIDX_W-1:0]   GRAN_FIRST    = 5'd6;
    localparam logic [WINDOW_W-1:0] CAPTURE_HEAD  = 24'h4F6767;
    localparam logic [BYTE_W-1:0]   CAPTURE_TAIL  = 8'h53;
    localparam logic [GRANULE_W-1:0] GRAN_INVALID = '1;

    typedef struct packed {
        logic              take;
        logic              last;
        logic [BYTE_W-1:0] data;
    } t_byte_item;

endpackage
`default_nettype wire

@@ hdl/ogg_lgs_parser.sv @@
// page header parser state and per-byte next-state logic
`default_nettype none
`include "ogg_last_granule_scanner_macros.svh"
module ogg_lgs_parser
    import ogg_lgs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_byte_item           i_item,
    output logic [GRANULE_W-1:0]      o_granule
);

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_SEGS   = 4'b0100,
        PH_BODY   = 4'b1000
    } t_phase;

    t_phase                r_phase,  n_phase;
    logic [WINDOW_W-1:0]   r_window, n_window;
    logic [HIDX_W-1:0]     r_hidx,   n_hidx;
    logic [GRANULE_W-1:0]  r_accum,  n_accum;
    logic [SEG_W-1:0]      r_segtot, n_segtot;
    logic [SEG_W-1:0]      r_segidx, n_segidx;
    logic [BODY_W-1:0]     r_body,   n_body;
    logic [GRANULE_W-1:0]  r_kept,   n_kept;
    logic                  w_last_take;
    logic                  w_cleared;
    logic                  w_hidx_ok;

    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_hidx   = r_hidx;
        n_accum  = r_accum;
        n_segtot = r_segtot;
        n_segidx = r_segidx;
        n_body   = r_body;
        n_kept   = r_kept;
        unique case (r_phase)
            PH_SEARCH: begin
                if (r_window == CAPTURE_HEAD && i_item.data == CAPTURE_TAIL) begin
                    n_phase  = PH_HEADER;
                    n_hidx   = HDR_START;
                    n_accum  = '0;
                    n_segtot = '0;
                    n_segidx = '0;
                    n_body   = '0;
                    n_window = '0;
                end else begin
                    n_window = {r_window[WINDOW_W-BYTE_W-1:0], i_item.data};
                end
            end
            PH_HEADER: begin
                for (int k = 0; k < GRAN_BYTES; k++) begin
                    if (r_hidx == GRAN_FIRST + HIDX_W'(k)) begin
                        n_accum[k*BYTE_W +: BYTE_W] = r_accum[k*BYTE_W +: BYTE_W]
                                                      | i_item.data;
                    end
                end
                if (r_hidx >= HDR_LAST) begin
                    n_segtot = i_item.data;
                    n_segidx = '0;
                    n_body   = '0;
                    n_hidx   = '0;
                    if (i_item.data == '0) begin
                        if (r_accum != GRAN_INVALID) begin
                            n_kept = r_accum;
                        end
                        n_phase  = PH_SEARCH;
                        n_window = '0;
                    end else begin
                        n_phase = PH_SEGS;
                    end
                end else begin
                    n_hidx = r_hidx + 1'b1;
                end
            end
            PH_SEGS: begin
                n_body   = r_body + BODY_W'(i_item.data);
                n_segidx = r_segidx + 1'b1;
                if (n_segidx >= r_segtot) begin
                    if (r_accum != GRAN_INVALID) begin
                        n_kept = r_accum;
                    end
                    if (n_body == '0) begin
                        n_phase  = PH_SEARCH;
                        n_window = '0;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (r_body != '0) begin
                    n_body = r_body - 1'b1;
                end
                if (n_body == '0) begin
                    n_phase  = PH_SEARCH;
                    n_window = '0;
                end
            end
            default: begin
                n_phase  = PH_SEARCH;
                n_window = '0;
            end
        endcase
    end

    assign o_granule = n_kept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_item.take && i_item.last)) begin
            r_phase  <= PH_SEARCH;
            r_window <= '0;
            r_hidx   <= '0;
            r_accum  <= '0;
            r_segtot <= '0;
            r_segidx <= '0;
            r_body   <= '0;
            r_kept   <= '0;
        end else if (i_item.take) begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_hidx   <= n_hidx;
            r_accum  <= n_accum;
            r_segtot <= n_segtot;
            r_segidx <= n_segidx;
            r_body   <= n_body;
            r_kept   <= n_kept;
        end
    end

    assign w_last_take = i_item.take && i_item.last;
    assign w_cleared   = (r_phase == PH_SEARCH) && (r_kept == '0);
    assign w_hidx_ok   = (r_hidx >= HDR_START) && (r_hidx <= HDR_LAST);

    `OGG_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_last_take, w_cleared)
    `OGG_ASSERT_NOW(a_hidx_range, i_clk, i_rst_n, r_phase == PH_HEADER, w_hidx_ok)
    `OGG_ASSERT_NOW(a_segidx_range, i_clk, i_rst_n, r_phase == PH_SEGS, r_segidx < r_segtot)

endmodule
`default_nettype wire

@@ hdl/ogg_last_granule_scanner.sv @@
// top level: input register, parser and result register
//
// Usage:
//   Input channel: one stream byte per transfer on i_data_byte, with
//   i_end_of_stream high on the final byte of a buffer. A transfer happens
//   when i_in_valid is high and o_in_stall is low.
//   Output channel: one o_end_granule per buffer, given only for the byte
//   flagged as end of stream; a transfer happens when o_out_valid is high
//   and i_out_stall is low. The value is the last granule, not all ones, of a
//   page with a whole header and segment table, or 0 if there was none.
//   o_out_valid rises after the final byte has passed the input register
//   and the parser has written its granule into the result register.
//   Throughput: one byte per cycle while no final byte waits; the parser
//   state is one register stage updated by one pass of next-state logic.
//   Stall: while the result register is full and stalled, ordinary bytes
//   still flow; only a further final byte waits in the input register.
//   After each final byte the parser returns to its reset state.
//   Reset: i_rst_n is synchronous, active low, and empties both registers
//   and clears all parser state.
`default_nettype none
`include "ogg_last_granule_scanner_macros.svh"
module ogg_last_granule_scanner
    import ogg_lgs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic [BYTE_W-1:0]     i_data_byte,
    input  wire logic                  i_end_of_stream,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output logic [GRANULE_W-1:0]       o_end_granule,
    input  wire logic                  i_out_stall
);

    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_eos;
    logic                 r_out_valid;
    logic [GRANULE_W-1:0] r_out_granule;
    logic                 w_take;
    logic [GRANULE_W-1:0] w_granule;
    t_byte_item           w_item;
    logic                 w_eos_held;

    assign w_take     = r_in_valid && (!r_in_eos || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_take;

    assign w_item.take = w_take;
    assign w_item.last = r_in_eos;
    assign w_item.data = r_in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    ogg_lgs_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (w_item),
        .o_granule (w_granule)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && r_in_eos) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_in_eos) begin
            r_out_granule <= w_granule;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_end_granule = r_out_granule;

    assign w_eos_held = r_in_valid && r_in_eos;

    `OGG_ASSERT_NEXT(a_last_fills_result, i_clk, i_rst_n, w_take && r_in_eos, r_out_valid)
    `OGG_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, o_in_stall, w_eos_held && r_out_valid)
    `OGG_ASSERT_NEXT(a_held_item_stays, i_clk, i_rst_n, r_in_valid && !w_take, w_eos_held)

endmodule
`default_nettype wire

@@ tb/tb_ogg_last_granule_scanner.sv @@
// self-checking testbench for the ogg last granule scanner: directed pages, then random streams
`default_nettype none
module tb_ogg_last_granule_scanner
    import ogg_lgs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD   = 150;
    localparam int RANDOM_BYTES = 80;
    localparam int MIN_STREAMS = 3;

    typedef enum logic [3:0] {
        SCAN_HUNT   = 4'b0001,
        SCAN_HEADER = 4'b0010,
        SCAN_LACING = 4'b0100,
        SCAN_BODY   = 4'b1000
    } t_scan_phase;

    typedef struct packed {
        int                   lead;
        bit                   has_page;
        logic [GRANULE_W-1:0] gran;
        int                   nseg;
        int                   lace_lo;
        int                   lace_hi;
        int                   keep;
        bit                   last;
        bit                   known;
        logic [GRANULE_W-1:0] want;
    } t_scan_row;

    localparam int NUM_ROWS = 17;
    localparam t_scan_row DIRECTED [NUM_ROWS] = '{
        // end of stream right after reset
        '{1, 0, 64'h0, 0, 0, 0, -1, 1, 1, 64'h0},
        '{0, 1, 64'h0123456789ABCDEF, 1, 3, 3, -1, 1, 1, 64'h0123456789ABCDEF},
        // all-ones granule alone
        '{2, 1, GRAN_INVALID, 2, 1, 4, -1, 1, 1, 64'h0},
        // empty segment table, then an all-ones page that must not replace it
        '{0, 1, 64'h8000000000000001, 0, 0, 0, -1, 0, 0, 64'h0},
        '{0, 1, GRAN_INVALID, 3, 0, 2, -1, 1, 1, 64'h8000000000000001},
        // header cut off
        '{3, 1, 64'h5, 1, 1, 1, 20, 1, 1, 64'h0},
        // ends on the capture tail
        '{0, 1, 64'hA, 1, 1, 1, 4, 1, 1, 64'h0},
        // segment table cut off after a good page
        '{0, 1, 64'h3, 1, 2, 2, -1, 0, 0, 64'h0},
        '{0, 1, 64'h7, 4, 1, 9, 29, 1, 1, 64'h3},
        // body cut off
        '{0, 1, 64'h9, 2, 5, 5, 32, 1, 1, 64'h9},
        // capture pattern inside the granule bytes
        '{0, 1, 64'h000000005367674F, 2, 0, 6, -1, 1, 1, 64'h000000005367674F},
        // full segment table with an empty body
        '{1, 1, 64'h1, 255, 0, 0, -1, 1, 1, 64'h1},
        '{0, 1, 64'h0, 1, 0, 0, -1, 0, 0, 64'h0},
        '{2, 0, 64'h0, 0, 0, 0, -1, 1, 1, 64'h0},
        '{0, 1, 64'hFFFFFFFFFFFFFFFE, 3, 0, 8, -1, 0, 0, 64'h0},
        '{4, 0, 64'h0, 0, 0, 0, -1, 1, 0, 64'h0},
        // largest lacing value, body cut off
        '{0, 1, 64'h2, 1, 255, 255, 40, 1, 1, 64'h2}
    };

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 i_end_of_stream = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [GRANULE_W-1:0] o_end_granule;
    logic                 i_out_stall = 1'b0;

    ogg_last_granule_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .o_end_granule   (o_end_granule),
        .i_out_stall     (i_out_stall)
    );

    // parser mirror
    logic [WINDOW_W-1:0]  hunt_win;
    t_scan_phase          scan_ph;
    logic [HIDX_W-1:0]    hdr_pos;
    logic [GRANULE_W-1:0] gran_acc;
    logic [SEG_W-1:0]     lace_count;
    logic [SEG_W-1:0]     lace_seen;
    logic [BODY_W-1:0]    body_left;
    logic [GRANULE_W-1:0] kept_gran;

    logic [GRANULE_W-1:0] granule_q [$];
    logic [BYTE_W-1:0]    row_bytes [$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_reqs = 0;
    int  fail_count = 0;
    int  bytes_sent = 0;
    int  pages_built = 0;
    int  results_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_ogg_last_granule_scanner failed");
        $finish;
    end

    function automatic void scan_clear();
        hunt_win   = '0;
        scan_ph    = SCAN_HUNT;
        hdr_pos    = '0;
        gran_acc   = '0;
        lace_count = '0;
        lace_seen  = '0;
        body_left  = '0;
        kept_gran  = '0;
    endfunction

    function automatic void page_done();
        if (gran_acc != GRAN_INVALID) begin
            kept_gran = gran_acc;
        end
        if (body_left == '0) begin
            scan_ph  = SCAN_HUNT;
            hunt_win = '0;
        end else begin
            scan_ph = SCAN_BODY;
        end
    endfunction

    function automatic void scan_predict(input logic [BYTE_W-1:0] b);
        case (scan_ph)
            SCAN_HUNT: begin
                if (hunt_win == CAPTURE_HEAD && b == CAPTURE_TAIL) begin
                    scan_ph    = SCAN_HEADER;
                    hdr_pos    = HDR_START;
                    gran_acc   = '0;
                    lace_count = '0;
                    lace_seen  = '0;
                    body_left  = '0;
                    hunt_win   = '0;
                end else begin
                    hunt_win = {hunt_win[WINDOW_W-BYTE_W-1:0], b};
                end
            end
            SCAN_HEADER: begin
                if (hdr_pos >= GRAN_FIRST && hdr_pos < GRAN_FIRST + GRAN_BYTES) begin
                    gran_acc = gran_acc | (GRANULE_W'(b) << (8 * (hdr_pos - GRAN_FIRST)));
                end
                if (hdr_pos >= HDR_LAST) begin
                    lace_count = b;
                    lace_seen  = '0;
                    body_left  = '0;
                    hdr_pos    = '0;
                    if (lace_count == '0) begin
                        page_done();
                    end else begin
                        scan_ph = SCAN_LACING;
                    end
                end else begin
                    hdr_pos = hdr_pos + 1'b1;
                end
            end
            SCAN_LACING: begin
                body_left = body_left + BODY_W'(b);
                lace_seen = lace_seen + 1'b1;
                if (lace_seen >= lace_count) begin
                    page_done();
                end
            end
            default: begin
                if (body_left != '0) begin
                    body_left = body_left - 1'b1;
                end
                if (body_left == '0) begin
                    scan_ph  = SCAN_HUNT;
                    hunt_win = '0;
                end
            end
        endcase
    endfunction

    function automatic void push_noise(input int n);
        for (int k = 0; k < n; k++) begin
            row_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void append_page(input logic [GRANULE_W-1:0] gran, input int nseg,
                                        input int lace_lo, input int lace_hi);
        int total;
        int lace;
        total = 0;
        row_bytes.push_back(CAPTURE_HEAD[23:16]);
        row_bytes.push_back(CAPTURE_HEAD[15:8]);
        row_bytes.push_back(CAPTURE_HEAD[7:0]);
        row_bytes.push_back(CAPTURE_TAIL);
        push_noise(2);
        for (int k = 0; k < GRAN_BYTES; k++) begin
            row_bytes.push_back(gran[8*k +: 8]);
        end
        push_noise(12);
        row_bytes.push_back(BYTE_W'(nseg));
        for (int s = 0; s < nseg; s++) begin
            lace = $urandom_range(lace_lo, lace_hi);
            row_bytes.push_back(BYTE_W'(lace));
            total += lace;
        end
        push_noise(total);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input bit known,
                             input logic [GRANULE_W-1:0] want);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        bytes_sent++;
        scan_predict(b);
        if (last) begin
            granule_q.push_back(known ? want : kept_gran);
            scan_clear();
        end
    endtask

    task automatic send_bytes(input logic last, input bit known, input logic [GRANULE_W-1:0] want);
        for (int k = 0; k < row_bytes.size(); k++) begin
            send_byte(row_bytes[k], last && (k == row_bytes.size() - 1), known, want);
        end
    endtask

    task automatic send_random_stream(input int max_pages);
        int n_pages;
        int nseg;
        int lace_hi;
        int mark;
        int cut;
        int pick;
        logic [GRANULE_W-1:0] gran;
        row_bytes.delete();
        n_pages = $urandom_range(0, max_pages);
        for (int p = 0; p < n_pages; p++) begin
            push_noise($urandom_range(0, 3));
            // broken capture pattern
            if ($urandom_range(0, 9) == 0) begin
                row_bytes.push_back(CAPTURE_HEAD[23:16]);
                row_bytes.push_back(CAPTURE_HEAD[15:8]);
                row_bytes.push_back(CAPTURE_HEAD[7:0]);
                row_bytes.push_back(CAPTURE_TAIL ^ BYTE_W'($urandom_range(1, 255)));
            end
            case ($urandom_range(0, 19))
                0, 1:    gran = GRAN_INVALID;
                2:       gran = '0;
                default: gran = {$urandom, $urandom};
            endcase
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                nseg    = $urandom_range(0, 6);
                lace_hi = $urandom_range(0, 12);
            end else if (pick < 18) begin
                nseg    = $urandom_range(7, 60);
                lace_hi = $urandom_range(0, 4);
            end else if (pick < 19) begin
                nseg    = $urandom_range(1, 3);
                lace_hi = 255;
            end else begin
                nseg    = 255;
                lace_hi = $urandom_range(0, 2);
            end
            mark = row_bytes.size();
            append_page(gran, nseg, 0, lace_hi);
            pages_built++;
            if ($urandom_range(0, 7) == 0) begin
                cut = $urandom_range(mark + 1, row_bytes.size());
                while (row_bytes.size() > cut) void'(row_bytes.pop_back());
            end
        end
        push_noise($urandom_range(n_pages == 0 ? 1 : 0, 2));
        send_bytes(1'b1, 1'b0, '0);
    endtask

    // output side: random stalls plus one long hold-off on request
    initial begin
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_reqs) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic [GRANULE_W-1:0] exp_gran;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            results_seen++;
            if (granule_q.size() == 0) begin
                $error("unexpected transfer: end_granule %h", o_end_granule);
                fail_count++;
            end else begin
                exp_gran = granule_q.pop_front();
                if (o_end_granule !== exp_gran) begin
                    $error("end_granule: expected %h, actual %h", exp_gran, o_end_granule);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int streams;
        int directed_bytes;
        int wait_cycles;
        scan_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 20;
        rx_idle_pct = 20;

        for (int i = 0; i < NUM_ROWS; i++) begin
            row_bytes.delete();
            push_noise(DIRECTED[i].lead);
            if (DIRECTED[i].has_page) begin
                append_page(DIRECTED[i].gran, DIRECTED[i].nseg, DIRECTED[i].lace_lo,
                            DIRECTED[i].lace_hi);
                pages_built++;
            end
            if (DIRECTED[i].keep >= 0) begin
                while (row_bytes.size() > DIRECTED[i].lead + DIRECTED[i].keep)
                    void'(row_bytes.pop_back());
            end
            send_bytes(DIRECTED[i].last, DIRECTED[i].known, DIRECTED[i].want);
        end

        directed_bytes = bytes_sent;
        streams = 0;
        while (bytes_sent - directed_bytes < RANDOM_BYTES || streams < MIN_STREAMS) begin
            if (streams % 8 == 0) begin
                case ($urandom_range(0, 2))
                    0:       tx_idle_pct = 0;
                    1:       tx_idle_pct = 10;
                    default: tx_idle_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0:       rx_idle_pct = 0;
                    1:       rx_idle_pct = 10;
                    default: rx_idle_pct = 30;
                endcase
            end
            // back pressure: short streams pile up behind a held output
            if (streams == 1) begin
                hold_reqs++;
                repeat (10) send_random_stream(0);
            end
            send_random_stream(2);
            streams++;
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (2) send_random_stream(1);
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (granule_q.size() != 0 && wait_cycles < 4000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (granule_q.size() != 0) begin
            $error("%0d expected end_granule transfers never arrived", granule_q.size());
            fail_count++;
        end
        repeat (10) @(posedge i_clk);

        $display("run covered %0d bytes in %0d pages, %0d granule results checked",
                 bytes_sent, pages_built, results_seen);
        $display("including cut-off pages, all-ones granules, full tables and output hold-off");
        if (fail_count == 0) begin
            $display("tb_ogg_last_granule_scanner passed");
        end else begin
            $display("tb_ogg_last_granule_scanner failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
